// ----- hdl/transmit_antenna_diversity_estimator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transmit antenna diversity estimator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRANSMIT_ANTENNA_DIVERSITY_ESTIMATOR_MACROS_SVH
`define TRANSMIT_ANTENNA_DIVERSITY_ESTIMATOR_MACROS_SVH

`ifndef SYNTH
// check a property on every rising clock edge outside reset
`define TADE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property on every rising clock edge, reset included
`define TADE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TADE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TADE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/tade_pkg.sv -----
// ----------------------------------------------------------------------------
// Transmit antenna diversity estimator package
// Types, constants and the random generator step shared by the modules.
// ----------------------------------------------------------------------------
package tade_pkg;

	// link status codes
	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_CRC1    = 2'd2,
		ST_VALID   = 2'd3
	} link_status_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RECEIVER_MODE = 2'd1;

	localparam logic [7:0] FRAME_PERIOD_RESET = 8'd20;

	typedef struct packed {
		logic [7:0] frame_period;
		logic       receiver_mode;
	} cfg_t;

	// estimator limits and steps
	localparam logic signed [7:0] EST_MAX = 8'sd125;
	localparam logic signed [7:0] EST_MIN = -8'sd125;
	localparam logic signed [9:0] STEP_RANGE_POS = 10'sd125;
	localparam logic signed [9:0] STEP_RANGE_NEG = -10'sd125;
	localparam logic signed [9:0] STEP_INVALID_POS = 10'sd75;
	localparam logic signed [9:0] STEP_INVALID_NEG = -10'sd75;

	localparam logic [2:0] CNT_MAX = 3'd5;

	// random generator
	localparam logic [30:0] LCG_A = 31'd214013;
	localparam logic [30:0] LCG_C = 31'd2531011;
	localparam logic [30:0] LCG_SEED_RESET = 31'd12345;

	// next seed, modulo 2^31
	function automatic logic [30:0] lcg_next(input logic [30:0] seed);
		lcg_next = seed * LCG_A + LCG_C;
	endfunction

	localparam logic [30:0] LCG_NEXT_RESET = lcg_next(LCG_SEED_RESET);

endpackage

// ----- hdl/tade_lcg.sv -----
// ----------------------------------------------------------------------------
// Tie-break random generator
// Holds the seed one step ahead so the decision bit is ready from a register.
// ----------------------------------------------------------------------------
module tade_lcg
	import tade_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	output logic rnd_bit
);

	logic [30:0] next_seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seed_q <= LCG_NEXT_RESET;
		end else if (advance) begin
			next_seed_q <= lcg_next(next_seed_q);
		end
	end

	assign rnd_bit = next_seed_q[30];

endmodule

// ----- hdl/tade_core.sv -----
// ----------------------------------------------------------------------------
// Estimator update core
// Invalid counters, step decision, clamp and antenna latch for one frame.
// ----------------------------------------------------------------------------
`include "transmit_antenna_diversity_estimator_macros.svh"

module tade_core
	import tade_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cfg_t              cfg,
	input  logic [1:0]        status_one,
	input  logic [1:0]        status_two,
	input  logic signed [7:0] rssi_one,
	input  logic signed [7:0] rssi_two,
	input  logic              rnd_bit,
	output logic              rnd_advance,
	output logic              antenna_d,
	output logic signed [7:0] level_d
);

	logic signed [7:0] est_q;
	logic              last_neg_q;
	logic [2:0]        cnt_one_q;
	logic [2:0]        cnt_two_q;
	logic              prop_q;

	logic [2:0]        cnt_one_d;
	logic [2:0]        cnt_two_d;
	logic              both_good;
	logic signed [9:0] period;
	logic signed [9:0] step;
	logic signed [9:0] sum;
	logic              tie_draw;

	function automatic logic [2:0] count_next(input logic [2:0] cnt, input logic [1:0] st);
		logic [2:0] res;
		res = cnt;
		if (st == ST_NONE || st == ST_INVALID) begin
			if (cnt < CNT_MAX) res = cnt + 3'd1;
		end else if (cnt != 3'd0) begin
			res = cnt - 3'd1;
		end
		return res;
	endfunction

	assign cnt_one_d = count_next(cnt_one_q, status_one);
	assign cnt_two_d = count_next(cnt_two_q, status_two);

	assign both_good = (status_one == ST_VALID && status_two == ST_VALID) ||
		(cfg.receiver_mode && status_one == ST_CRC1 && status_two == ST_CRC1);

	assign period = signed'({2'b00, cfg.frame_period});

	always_comb begin
		step     = '0;
		tie_draw = 1'b0;
		if (both_good) begin
			if (rssi_one > rssi_two) step = period;
			else if (rssi_one < rssi_two) step = -period;
			else step = '0;
		end else if (status_one > status_two) begin
			step = STEP_INVALID_POS;
		end else if (status_one < status_two) begin
			step = STEP_INVALID_NEG;
		end else if (status_one == ST_INVALID) begin
			if (cnt_one_d < cnt_two_d) begin
				step = STEP_RANGE_POS;
			end else if (cnt_one_d > cnt_two_d) begin
				step = STEP_RANGE_NEG;
			end else begin
				tie_draw = 1'b1;
				step = rnd_bit ? STEP_RANGE_POS : STEP_RANGE_NEG;
			end
		end else if (!last_neg_q) begin
			// sweep up until the top limit, then turn
			step = (est_q < EST_MAX) ? period : -period;
		end else begin
			step = (est_q > EST_MIN) ? -period : period;
		end
	end

	assign rnd_advance = en && tie_draw;
	assign sum = 10'(est_q) + step;

	always_comb begin
		level_d   = est_q;
		antenna_d = prop_q;
		if (sum >= STEP_RANGE_POS) begin
			level_d   = EST_MAX;
			antenna_d = 1'b0;
		end else if (sum <= STEP_RANGE_NEG) begin
			level_d   = EST_MIN;
			antenna_d = 1'b1;
		end else begin
			level_d = sum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q      <= EST_MAX;
			last_neg_q <= 1'b0;
			cnt_one_q  <= '0;
			cnt_two_q  <= '0;
			prop_q     <= 1'b0;
		end else if (en) begin
			est_q      <= level_d;
			last_neg_q <= step[9];
			cnt_one_q  <= cnt_one_d;
			cnt_two_q  <= cnt_two_d;
			prop_q     <= antenna_d;
		end
	end

	`TADE_ASSERT(a_est_range, clk, arst_n, est_q <= EST_MAX && est_q >= EST_MIN, "estimator range")
	`TADE_ASSERT(a_cnt_one, clk, arst_n, cnt_one_q <= CNT_MAX, "counter one above limit")
	`TADE_ASSERT(a_cnt_two, clk, arst_n, cnt_two_q <= CNT_MAX, "counter two above limit")
	`TADE_ASSERT(a_top_latch, clk, arst_n, (est_q == EST_MAX) |-> (prop_q == 1'b0), "upper limit without antenna 1")
	`TADE_ASSERT(a_bot_latch, clk, arst_n, (est_q == EST_MIN) |-> (prop_q == 1'b1), "lower limit without antenna 2")

endmodule

// ----- hdl/transmit_antenna_diversity_estimator.sv -----
// An accepted request waits in the input register until the result register is free.
// Throughput: one frame per cycle unless m_axis stalls; a single register pass per frame.
// The state update, clamp and tie-break bit are all settled in the cycle between the
// input register and the result register.
// Reset: estimator 125, counters 0, antenna 1 proposed, seed 12345, period 20, mode 0.
// ----------------------------------------------------------------------------
// Transmit antenna diversity estimator
// Proposes the transmit antenna from per-frame link status and RSSI of two antennas.
// ----------------------------------------------------------------------------
`include "transmit_antenna_diversity_estimator_macros.svh"

module transmit_antenna_diversity_estimator
	import tade_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data,
	// frame input
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [23:0]            s_axis_tdata,  // status_one[1:0], status_two[3:2], rssi_one[11:4], rssi_two[19:12], zero[23:20]
	// result output
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata   // antenna_choice[0], estimator_level[8:1], zero[15:9]
);

	cfg_t cfg_q;

	logic              valid_s1;
	logic [1:0]        status_one_s1;
	logic [1:0]        status_two_s1;
	logic signed [7:0] rssi_one_s1;
	logic signed [7:0] rssi_two_s1;

	logic              out_valid_q;
	logic              antenna_q;
	logic signed [7:0] level_q;

	logic              advance;
	logic              process;
	logic              rnd_bit;
	logic              rnd_advance;
	logic              antenna_d;
	logic signed [7:0] level_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period  <= FRAME_PERIOD_RESET;
			cfg_q.receiver_mode <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_PERIOD:  cfg_q.frame_period  <= cfg_data;
				REG_RECEIVER_MODE: cfg_q.receiver_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the result register frees up when empty or drained this cycle
	assign advance       = !out_valid_q || m_axis_tready;
	assign process       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			status_one_s1 <= s_axis_tdata[1:0];
			status_two_s1 <= s_axis_tdata[3:2];
			rssi_one_s1   <= s_axis_tdata[11:4];
			rssi_two_s1   <= s_axis_tdata[19:12];
		end
	end

	tade_lcg u_lcg (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (rnd_advance),
		.rnd_bit (rnd_bit)
	);

	tade_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (process),
		.cfg         (cfg_q),
		.status_one  (status_one_s1),
		.status_two  (status_two_s1),
		.rssi_one    (rssi_one_s1),
		.rssi_two    (rssi_two_s1),
		.rnd_bit     (rnd_bit),
		.rnd_advance (rnd_advance),
		.antenna_d   (antenna_d),
		.level_d     (level_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			antenna_q <= antenna_d;
			level_q   <= level_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, level_q, antenna_q};

	`TADE_ASSERT(a_hold_s1, clk, arst_n, (valid_s1 && !advance) |=> valid_s1, "pending request dropped")
	`TADE_ASSERT(a_fill_out, clk, arst_n, process |=> out_valid_q, "processed request produced no result")

endmodule

// ----- sim/tb_transmit_antenna_diversity_estimator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the transmit antenna diversity estimator
// Drives frames of link status and RSSI through the stream input. A behavioral
// estimator or the directed table predicts each result; checked field by field.
// Runs directed corner frames, then random frames under several register settings.
// ----------------------------------------------------------------------------
module tb_transmit_antenna_diversity_estimator;
	import tade_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int FRAMES_PER_PHASE = 200;
	localparam int N_DIRECTED = 24;
	localparam int EST_LIMIT = 125;
	localparam int INVALID_STEP = 75;
	localparam logic signed [7:0] RSSI_MIN = 8'sh80;
	localparam logic signed [7:0] RSSI_MAX = 8'sh7F;
	// indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		bit                antenna;
		logic signed [7:0] level;
	} proposal_t;

	typedef struct {
		link_status_t      st_one;
		link_status_t      st_two;
		logic signed [7:0] rssi_one;
		logic signed [7:0] rssi_two;
		bit                typed;
		bit                antenna;
		logic signed [7:0] level;
	} frame_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [23:0]            s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [15:0]            m_axis_tdata;

	// estimator copy
	int          frame_period;
	bit          rx_mode;
	int          est_level;
	bit          step_was_negative;
	int          invalid_one;
	int          invalid_two;
	logic [30:0] lcg_state;
	bit          proposed_ant;

	proposal_t   pending_proposals[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_cycle = 0;
	frame_row_t  directed_rows[N_DIRECTED];

	transmit_antenna_diversity_estimator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // status_one[1:0], status_two[3:2], rssi_one[11:4], rssi_two[19:12]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)   // antenna_choice[0], estimator_level[8:1]
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int bump_count(input int cnt, input link_status_t st);
		if (st == ST_NONE || st == ST_INVALID) begin
			bump_count = (cnt < 5) ? cnt + 1 : cnt;
		end else begin
			bump_count = (cnt > 0) ? cnt - 1 : cnt;
		end
	endfunction

	function automatic proposal_t advance_estimator(input link_status_t s1, input link_status_t s2,
			input logic signed [7:0] r1, input logic signed [7:0] r2);
		int               step;
		bit               good;
		longint unsigned  prod;
		proposal_t        p;
		invalid_one = bump_count(invalid_one, s1);
		invalid_two = bump_count(invalid_two, s2);
		good = (s1 == ST_VALID && s2 == ST_VALID) ||
			(rx_mode && s1 == ST_CRC1 && s2 == ST_CRC1);
		if (good) begin
			if (r1 > r2) step = frame_period;
			else if (r1 < r2) step = -frame_period;
			else step = 0;
		end else if (int'(s1) > int'(s2)) begin
			step = INVALID_STEP;
		end else if (int'(s1) < int'(s2)) begin
			step = -INVALID_STEP;
		end else if (s1 == ST_INVALID) begin
			if (invalid_one < invalid_two) step = EST_LIMIT;
			else if (invalid_one > invalid_two) step = -EST_LIMIT;
			else begin
				// tie: advance the generator and take bit 30
				prod = lcg_state * 64'd214013 + 64'd2531011;
				lcg_state = prod[30:0];
				step = lcg_state[30] ? EST_LIMIT : -EST_LIMIT;
			end
		end else if (!step_was_negative) begin
			step = (est_level < EST_LIMIT) ? frame_period : -frame_period;
		end else begin
			step = (est_level > -EST_LIMIT) ? -frame_period : frame_period;
		end
		est_level = est_level + step;
		if (est_level >= EST_LIMIT) begin
			est_level = EST_LIMIT;
			proposed_ant = 1'b0;
		end
		if (est_level <= -EST_LIMIT) begin
			est_level = -EST_LIMIT;
			proposed_ant = 1'b1;
		end
		step_was_negative = (step < 0);
		p.antenna = proposed_ant;
		p.level = 8'(est_level);
		return p;
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_frame(input frame_row_t row);
		proposal_t p;
		int        gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tdata = {4'd0, row.rssi_two, row.rssi_one, row.st_two, row.st_one};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		p = advance_estimator(row.st_one, row.st_two, row.rssi_one, row.rssi_two);
		if (row.typed) begin
			p.antenna = row.antenna;
			p.level = row.level;
		end
		pending_proposals.push_back(p);
		@(negedge clk);
	endtask

	// hold off until every proposal is back, then let the pipeline settle
	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (pending_proposals.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		drain_results();
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_FRAME_PERIOD) frame_period = int'(value);
		else if (idx == REG_RECEIVER_MODE) rx_mode = value[0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_frame(output frame_row_t row);
		row.typed = 1'b0;
		row.antenna = 1'b0;
		row.level = '0;
		row.rssi_one = 8'($urandom);
		row.rssi_two = 8'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				row.st_one = ST_VALID;
				row.st_two = ST_VALID;
			end
			3, 4: begin
				row.st_one = link_status_t'($urandom_range(0, 3));
				row.st_two = link_status_t'($urandom_range(0, 3));
				if (row.st_one == row.st_two) row.st_two = link_status_t'(row.st_one ^ 2'b01);
			end
			5, 6: begin
				row.st_one = ST_INVALID;
				row.st_two = ST_INVALID;
			end
			7: begin
				row.st_one = ST_NONE;
				row.st_two = ST_NONE;
			end
			8: begin
				row.st_one = ST_CRC1;
				row.st_two = ST_CRC1;
			end
			default: begin
				row.st_one = link_status_t'($urandom_range(0, 3));
				row.st_two = link_status_t'($urandom_range(0, 3));
			end
		endcase
		case ($urandom_range(0, 7))
			0: row.rssi_two = row.rssi_one;
			1: begin
				row.rssi_one = RSSI_MAX;
				row.rssi_two = RSSI_MIN;
			end
			2: begin
				row.rssi_one = RSSI_MIN;
				row.rssi_two = RSSI_MAX;
			end
			default: ;
		endcase
	endtask

	// receiver stall pattern: free running, random, or a periodic ready and stall pattern
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 50 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = ($urandom_range(0, 9) < 7);
			default: m_axis_tready = ((stall_cycle % 5) < 3);
		endcase
	end

	always @(posedge clk) begin
		proposal_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_proposals.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: antenna %0d level %0d",
						m_axis_tdata[0], $signed(m_axis_tdata[8:1]));
				mismatches++;
			end else begin
				want = pending_proposals.pop_front();
				if (m_axis_tdata[0] !== want.antenna || m_axis_tdata[8:1] !== want.level) begin
					if (mismatches < 10)
						$display("mismatch: expected antenna %0d level %0d, got antenna %0d level %0d",
							want.antenna, want.level, m_axis_tdata[0],
							$signed(m_axis_tdata[8:1]));
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout with %0d results outstanding", pending_proposals.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		frame_row_t row;
		frame_period = int'(FRAME_PERIOD_RESET);
		rx_mode = 1'b0;
		est_level = EST_LIMIT;
		step_was_negative = 1'b0;
		invalid_one = 0;
		invalid_two = 0;
		lcg_state = LCG_SEED_RESET;
		proposed_ant = 1'b0;

		directed_rows = '{
			'{ST_NONE,    ST_NONE,    8'sd0,    8'sd0,    1'b1, 1'b0, 8'sd105},
			'{ST_VALID,   ST_VALID,   RSSI_MAX, RSSI_MIN, 1'b1, 1'b0, 8'sd125},
			'{ST_VALID,   ST_VALID,   RSSI_MIN, RSSI_MAX, 1'b1, 1'b0, 8'sd105},
			'{ST_VALID,   ST_VALID,   -8'sd5,   -8'sd5,   1'b1, 1'b0, 8'sd105},
			'{ST_VALID,   ST_NONE,    8'sd0,    8'sd0,    1'b1, 1'b0, 8'sd125},
			'{ST_NONE,    ST_VALID,   8'sd3,    8'sd4,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_CRC1,    RSSI_MIN, RSSI_MIN, 1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_VALID,   RSSI_MAX, RSSI_MAX, 1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_VALID,   8'sd1,    8'sd2,    1'b0, 1'b0, 8'sd0},
			'{ST_CRC1,    ST_CRC1,    8'sd10,   -8'sd10,  1'b0, 1'b0, 8'sd0},
			'{ST_CRC1,    ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_VALID,   ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_VALID,   ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_INVALID, ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_NONE,    ST_INVALID, 8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_VALID,   ST_CRC1,    RSSI_MIN, RSSI_MAX, 1'b0, 1'b0, 8'sd0},
			'{ST_NONE,    ST_NONE,    8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0},
			'{ST_NONE,    ST_NONE,    8'sd0,    8'sd0,    1'b0, 1'b0, 8'sd0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) send_frame(directed_rows[i]);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_FRAME_PERIOD, 8'd255);
					write_reg(REG_RECEIVER_MODE, 8'd1);
					write_reg(REG_SPARE_A, 8'($urandom));
				end
				1: begin
					write_reg(REG_FRAME_PERIOD, 8'd1);
					write_reg(REG_RECEIVER_MODE, 8'hFE);
				end
				2: begin
					// zero period: every sweep and RSSI step is zero
					write_reg(REG_FRAME_PERIOD, 8'd0);
					write_reg(REG_RECEIVER_MODE, 8'd1);
					write_reg(REG_SPARE_B, 8'($urandom));
				end
				3: begin
					write_reg(REG_FRAME_PERIOD, 8'($urandom_range(1, 254)));
					write_reg(REG_RECEIVER_MODE, 8'd0);
				end
				default: begin
					write_reg(REG_FRAME_PERIOD, 8'($urandom_range(1, 255)));
					write_reg(REG_RECEIVER_MODE, 8'($urandom));
				end
			endcase
			for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
				random_frame(row);
				send_frame(row);
				if ($urandom_range(0, 149) == 0) drain_results();
			end
		end

		drain_results();
		if (mismatches == 0 && pending_proposals.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
